[src/e2p_pkg.sv]
package e2p_pkg;

  localparam int RayW       = 35;
  localparam int CordW      = 38;
  localparam int AngW       = 27;
  localparam int CordSteps  = 20;
  localparam int QDepth     = 4;
  localparam int QPtrW      = $clog2(QDepth);
  localparam int QCntW      = QPtrW + 1;
  localparam int PersMaxDim = 4096;

  localparam logic signed [AngW-1:0] HalfTurn    = AngW'(8388608);
  localparam logic signed [AngW-1:0] QuarterTurn = AngW'(4194304);
  localparam logic signed [AngW-1:0] NegQuarter  = -AngW'(4194304);
  localparam logic [23:0]            InvGain     = 24'd10188014;

  localparam logic [2:0] RegMatX   = 3'd0;
  localparam logic [2:0] RegMatY   = 3'd1;
  localparam logic [2:0] RegMatZ   = 3'd2;
  localparam logic [2:0] RegWidth  = 3'd3;
  localparam logic [2:0] RegHeight = 3'd4;

  typedef struct packed {
    logic [62:0] mx;
    logic [62:0] my;
    logic [62:0] mz;
    logic [10:0] width;
    logic [9:0]  height;
  } cfg_t;

  typedef struct packed {
    logic                   is_load;
    logic [11:0]            col;
    logic [11:0]            row;
    logic [23:0]            rgb;
    logic signed [RayW-1:0] x;
    logic signed [RayW-1:0] y;
    logic signed [RayW-1:0] z;
  } item_t;

  typedef struct packed {
    logic                   is_load;
    logic [11:0]            col;
    logic [11:0]            row;
    logic [23:0]            rgb;
    logic signed [RayW-1:0] y;
    logic [23:0]            t;
  } side_t;

  function automatic logic signed [AngW-1:0] atan_turns(input int unsigned i);
    logic signed [AngW-1:0] r;
    unique case (i)
      0:       r = AngW'(2097152);
      1:       r = AngW'(1238021);
      2:       r = AngW'(654136);
      3:       r = AngW'(332050);
      4:       r = AngW'(166669);
      5:       r = AngW'(83416);
      6:       r = AngW'(41718);
      7:       r = AngW'(20860);
      8:       r = AngW'(10430);
      9:       r = AngW'(5215);
      10:      r = AngW'(2608);
      11:      r = AngW'(1304);
      12:      r = AngW'(652);
      13:      r = AngW'(326);
      14:      r = AngW'(163);
      15:      r = AngW'(81);
      16:      r = AngW'(41);
      17:      r = AngW'(20);
      18:      r = AngW'(10);
      19:      r = AngW'(5);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[src/e2p_queue.sv]
module e2p_queue import e2p_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  item_t            item_i,
  input  logic             pop_i,
  output logic             empty_o,
  output item_t            head_o,
  output logic [QCntW-1:0] count_o
);

  item_t             slot_q [QDepth];
  logic [QPtrW-1:0]  wptr_q, rptr_q;
  logic [QCntW-1:0]  cnt_q;

  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + QCntW'(push_i) - QCntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= item_i;
  end

endmodule

[src/e2p_front.sv]
module e2p_front import e2p_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [47:0]      s_axis_tdata_i,
  input  logic             s_axis_tuser_i,
  input  cfg_t             cfg_i,
  input  logic [QCntW-1:0] q_count_i,
  output logic             push_o,
  output item_t            item_o
);

  logic              fire;
  logic [11:0]       col, row, col_sat, row_sat;
  logic [62:0]       mrow [3];
  logic signed [33:0] pc_d [3], pr_d [3];
  logic signed [33:0] pc_q [3], pr_q [3];
  logic signed [20:0] k_q [3];
  logic              f1_v_q, f2_v_q, f1_load_q;
  logic [11:0]       f1_col_q, f1_row_q;
  logic [23:0]       f1_rgb_q;
  item_t             f2_q;
  logic [QCntW:0]    used;

  assign col = s_axis_tdata_i[11:0];
  assign row = s_axis_tdata_i[23:12];
  assign col_sat = (32'(col) > PersMaxDim - 1) ? 12'(PersMaxDim - 1) : col;
  assign row_sat = (32'(row) > PersMaxDim - 1) ? 12'(PersMaxDim - 1) : row;

  assign used = {1'b0, q_count_i} + (QCntW + 1)'(f1_v_q) + (QCntW + 1)'(f2_v_q);
  assign s_axis_tready_o = used < (QCntW + 1)'(QDepth);
  assign fire = s_axis_tvalid_i && s_axis_tready_o;

  assign mrow[0] = cfg_i.mx;
  assign mrow[1] = cfg_i.my;
  assign mrow[2] = cfg_i.mz;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pc_d[j] = $signed(mrow[j][20:0]) * $signed({1'b0, col_sat});
      pr_d[j] = $signed(mrow[j][41:21]) * $signed({1'b0, row_sat});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else begin
      f1_v_q <= fire;
      f2_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      f1_load_q <= !s_axis_tuser_i;
      f1_col_q  <= col;
      f1_row_q  <= row;
      f1_rgb_q  <= {s_axis_tdata_i[31:24], s_axis_tdata_i[39:32], s_axis_tdata_i[47:40]};
      for (int j = 0; j < 3; j++) begin
        pc_q[j] <= pc_d[j];
        pr_q[j] <= pr_d[j];
        k_q[j]  <= $signed(mrow[j][62:42]);
      end
    end
    if (f1_v_q) begin
      f2_q.is_load <= f1_load_q;
      f2_q.col     <= f1_col_q;
      f2_q.row     <= f1_row_q;
      f2_q.rgb     <= f1_rgb_q;
      f2_q.x <= RayW'(pc_q[0]) + RayW'(pr_q[0]) + RayW'(k_q[0]);
      f2_q.y <= RayW'(pc_q[1]) + RayW'(pr_q[1]) + RayW'(k_q[1]);
      f2_q.z <= RayW'(pc_q[2]) + RayW'(pr_q[2]) + RayW'(k_q[2]);
    end
  end

  assign push_o = f2_v_q;
  assign item_o = f2_q;

endmodule

[src/e2p_cordic.sv]
module e2p_cordic import e2p_pkg::*; #(
  parameter int SideW = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [CordW-1:0] a_i,
  input  logic signed [CordW-1:0] b_i,
  input  logic [SideW-1:0]        side_i,
  output logic                    valid_o,
  output logic signed [CordW-1:0] mag_o,
  output logic signed [AngW-1:0]  ang_o,
  output logic [SideW-1:0]        side_o
);

  logic [CordSteps:0]      v_q;
  logic                    z_q [CordSteps+1];
  logic signed [CordW-1:0] a_q [CordSteps+1];
  logic signed [CordW-1:0] b_q [CordSteps+1];
  logic signed [AngW-1:0]  ang_q [CordSteps+1];
  logic [SideW-1:0]        side_q [CordSteps+1];
  logic                    neg;

  assign neg = a_i < 0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[CordSteps-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0]    <= (a_i == 0) && (b_i == 0);
      a_q[0]    <= neg ? -a_i : a_i;
      b_q[0]    <= neg ? -b_i : b_i;
      ang_q[0]  <= neg ? HalfTurn : '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < CordSteps; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[i+1]    <= z_q[i];
        side_q[i+1] <= side_q[i];
        if (b_q[i] < 0) begin
          a_q[i+1]   <= a_q[i] - (b_q[i] >>> i);
          b_q[i+1]   <= b_q[i] + (a_q[i] >>> i);
          ang_q[i+1] <= ang_q[i] - atan_turns(i);
        end else begin
          a_q[i+1]   <= a_q[i] + (b_q[i] >>> i);
          b_q[i+1]   <= b_q[i] - (a_q[i] >>> i);
          ang_q[i+1] <= ang_q[i] + atan_turns(i);
        end
      end
    end
  end

  assign valid_o = v_q[CordSteps];
  assign mag_o   = z_q[CordSteps] ? '0 : a_q[CordSteps];
  assign ang_o   = z_q[CordSteps] ? '0 : ang_q[CordSteps];
  assign side_o  = side_q[CordSteps];

endmodule

[src/e2p_back.sv]
module e2p_back import e2p_pkg::*; #(
  parameter int PANO_MAX_WIDTH  = 1024,
  parameter int PANO_MAX_HEIGHT = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_empty_i,
  input  item_t       q_head_i,
  output logic        q_pop_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o
);

  localparam int CW        = $clog2(PANO_MAX_WIDTH);
  localparam int RW        = $clog2(PANO_MAX_HEIGHT);
  localparam int AW        = CW + RW - 1;
  localparam int BankDepth = 2 ** AW;

  localparam int SideW = $bits(side_t);

  logic adv;
  logic [10:0] wc;
  logic [9:0]  hc;

  logic out_v_q;
  logic [23:0] out_q;

  assign adv = !out_v_q || m_axis_tready_i;
  assign q_pop_o = adv && !q_empty_i;

  assign wc = (cfg_i.width < 11'd2) ? 11'd2 :
              (32'(cfg_i.width) > PANO_MAX_WIDTH) ? 11'(PANO_MAX_WIDTH) : cfg_i.width;
  assign hc = (cfg_i.height < 10'd2) ? 10'd2 :
              (32'(cfg_i.height) > PANO_MAX_HEIGHT) ? 10'(PANO_MAX_HEIGHT) : cfg_i.height;

  // theta pass
  side_t side0, side1, side1t, side2;
  logic c1_v, c2_v;
  logic signed [CordW-1:0] c1_mag, c2_mag;
  logic signed [AngW-1:0]  c1_ang, c2_ang;
  logic [SideW-1:0] side1_raw, side2_raw;

  always_comb begin
    side0.is_load = q_head_i.is_load;
    side0.col     = q_head_i.col;
    side0.row     = q_head_i.row;
    side0.rgb     = q_head_i.rgb;
    side0.y       = q_head_i.y;
    side0.t       = '0;
  end

  e2p_cordic #(.SideW(SideW)) u_theta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (!q_empty_i),
    .a_i     (CordW'(q_head_i.z)),
    .b_i     (CordW'(q_head_i.x)),
    .side_i  (SideW'(side0)),
    .valid_o (c1_v),
    .mag_o   (c1_mag),
    .ang_o   (c1_ang),
    .side_o  (side1_raw)
  );

  assign side1 = side_t'(side1_raw);

  // scale magnitude by inverse gain
  logic g1_v_q, g2_v_q;
  logic [41:0] ph_q, pl_q;
  side_t g1_side_q, g2_side_q;
  logic [35:0] m2_q;
  logic [59:0] gsum;
  logic signed [AngW-1:0] tsum;

  assign tsum = c1_ang + HalfTurn;
  assign gsum = {ph_q, 18'b0} + 60'(pl_q);

  always_comb begin
    side1t   = side1;
    side1t.t = tsum[23:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ph_q      <= 42'(c1_mag[35:18]) * 42'(InvGain);
      pl_q      <= 42'(c1_mag[17:0]) * 42'(InvGain);
      g1_side_q <= side1t;
      m2_q      <= gsum[59:24];
      g2_side_q <= g1_side_q;
    end
  end

  // phi pass
  e2p_cordic #(.SideW(SideW)) u_phi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (g2_v_q),
    .a_i     (CordW'(m2_q)),
    .b_i     (CordW'(g2_side_q.y)),
    .side_i  (SideW'(g2_side_q)),
    .valid_o (c2_v),
    .mag_o   (c2_mag),
    .ang_o   (c2_ang),
    .side_o  (side2_raw)
  );

  assign side2 = side_t'(side2_raw);

  // map angles to panorama coordinates
  logic signed [AngW-1:0] phi_c, vq_s;
  logic m1_v_q, m2_v_q;
  logic [34:0] pu_q;
  logic [33:0] pv_q;
  side_t m1_side_q;

  assign phi_c = (c2_ang > QuarterTurn) ? QuarterTurn :
                 (c2_ang < NegQuarter) ? NegQuarter : c2_ang;
  assign vq_s  = phi_c + QuarterTurn;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pu_q      <= 35'(side2.t) * 35'(wc);
      pv_q      <= 34'(vq_s[23:0]) * 34'(hc);
      m1_side_q <= side2;
    end
  end

  logic signed [19:0] u8s, v8s;
  logic [18:0] u8c, v8c;
  logic [10:0] u0w, u1w, v0r, v0w, v1w;
  logic [11:0] u0inc, v0inc;
  logic        wr_ok;

  assign u8s = $signed({1'b0, pu_q[34:16]}) - 20'sd128;
  assign v8s = $signed({1'b0, pv_q[33:15]}) - 20'sd128;
  assign u8c = (u8s < 0) ? '0 : u8s[18:0];
  assign v8c = (v8s < 0) ? '0 : v8s[18:0];
  assign u0w = u8c[18:8];
  assign u0inc = {1'b0, u0w} + 12'd1;
  assign u1w = (u0inc == {1'b0, wc}) ? '0 : u0inc[10:0];
  assign v0r = v8c[18:8];
  assign v0w = (v0r > 11'(hc - 10'd1)) ? 11'(hc - 10'd1) : v0r;
  assign v0inc = {1'b0, v0w} + 12'd1;
  assign v1w = (v0inc > 12'(hc - 10'd1)) ? 11'(hc - 10'd1) : v0inc[10:0];
  assign wr_ok = (32'(m1_side_q.col) < PANO_MAX_WIDTH) && (32'(m1_side_q.row) < PANO_MAX_HEIGHT);

  logic [CW-1:0] u0_q, u1_q, wcol_q;
  logic [RW-1:0] v0_q, v1_q, wrow_q;
  logic [7:0]    fu_q, fv_q;
  logic          m2_load_q, m2_wr_q;
  logic [23:0]   wrgb_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u0_q      <= CW'(u0w);
      u1_q      <= CW'(u1w);
      v0_q      <= RW'(v0w);
      v1_q      <= RW'(v1w);
      fu_q      <= u8c[7:0];
      fv_q      <= v8c[7:0];
      m2_load_q <= m1_side_q.is_load;
      m2_wr_q   <= wr_ok;
      wcol_q    <= CW'(m1_side_q.col);
      wrow_q    <= RW'(m1_side_q.row);
      wrgb_q    <= m1_side_q.rgb;
    end
  end

  // panorama store, split by row parity, two column reads per bank
  logic [23:0] bank0_mem [BankDepth];
  logic [23:0] bank1_mem [BankDepth];
  logic [23:0] rd0a_q, rd0b_q, rd1a_q, rd1b_q;
  logic [RW-2:0] r0, r1;
  logic [AW-1:0] waddr;
  logic          we;

  assign r0 = v0_q[0] ? v1_q[RW-1:1] : v0_q[RW-1:1];
  assign r1 = v0_q[0] ? v0_q[RW-1:1] : v1_q[RW-1:1];
  assign waddr = {wrow_q[RW-1:1], wcol_q};
  assign we = adv && m2_v_q && m2_load_q && m2_wr_q;

  always_ff @(posedge clk_i) begin
    if (we && !wrow_q[0]) bank0_mem[waddr] <= wrgb_q;
    if (adv) begin
      rd0a_q <= bank0_mem[{r0, u0_q}];
      rd0b_q <= bank0_mem[{r0, u1_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we && wrow_q[0]) bank1_mem[waddr] <= wrgb_q;
    if (adv) begin
      rd1a_q <= bank1_mem[{r1, u0_q}];
      rd1b_q <= bank1_mem[{r1, u1_q}];
    end
  end

  logic        r_v_q, sel_q, same_q;
  logic [16:0] wt_q [4];
  logic [8:0]  wau, wav;

  assign wau = 9'd256 - {1'b0, fu_q};
  assign wav = 9'd256 - {1'b0, fv_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sel_q   <= v0_q[0];
      same_q  <= (v0_q == v1_q);
      wt_q[0] <= 17'(wau) * 17'(wav);
      wt_q[1] <= 17'(wau) * 17'(fv_q);
      wt_q[2] <= 17'(fu_q) * 17'(wav);
      wt_q[3] <= 17'(fu_q) * 17'(fv_q);
    end
  end

  // blend
  logic [23:0] pix [4];
  logic        p_v_q;
  logic [24:0] prod_q [3][4];
  logic [26:0] acc [3];

  always_comb begin
    pix[0] = sel_q ? rd1a_q : rd0a_q;
    pix[2] = sel_q ? rd1b_q : rd0b_q;
    pix[1] = same_q ? pix[0] : (sel_q ? rd0a_q : rd1a_q);
    pix[3] = same_q ? pix[2] : (sel_q ? rd0b_q : rd1b_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int k = 0; k < 4; k++) begin
          prod_q[ch][k] <= 25'(pix[k][23 - 8*ch -: 8]) * 25'(wt_q[k]);
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = 27'(prod_q[ch][0]) + 27'(prod_q[ch][1]) +
                27'(prod_q[ch][2]) + 27'(prod_q[ch][3]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_v_q  <= 1'b0;
      g2_v_q  <= 1'b0;
      m1_v_q  <= 1'b0;
      m2_v_q  <= 1'b0;
      r_v_q   <= 1'b0;
      p_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      g1_v_q  <= c1_v;
      g2_v_q  <= g1_v_q;
      m1_v_q  <= c2_v;
      m2_v_q  <= m1_v_q;
      r_v_q   <= m2_v_q && !m2_load_q;
      p_v_q   <= r_v_q;
      out_v_q <= p_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= {acc[2][23:16], acc[1][23:16], acc[0][23:16]};
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;

endmodule

[src/equirect_to_perspective_sampler_unit.sv]
// Throughput: one beat per cycle while the output is not stalled; the two CORDIC
// pipelines and the dual-bank panorama store each take a new item every such cycle.
// Load beats write the store if col and row fit the panorama; they give no output beat.
// Reset: asynchronous, active low; clears control state and sets the
// matrix rows to zero, width to 1024 and height to 512. The store is not cleared.
module equirect_to_perspective_sampler_unit import e2p_pkg::*; #(
  parameter int PANO_MAX_WIDTH  = 1024,
  parameter int PANO_MAX_HEIGHT = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // col, row, red_in, green_in, blue_in
  input  logic        s_axis_tuser_i,  // cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // red_out, green_out, blue_out
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [62:0] cfg_data_i
);

  cfg_t             cfg_q;
  logic             push, pop, q_empty;
  item_t            push_item, head;
  logic [QCntW-1:0] q_count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mx     <= '0;
      cfg_q.my     <= '0;
      cfg_q.mz     <= '0;
      cfg_q.width  <= 11'd1024;
      cfg_q.height <= 10'd512;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        RegMatX:   cfg_q.mx     <= cfg_data_i;
        RegMatY:   cfg_q.my     <= cfg_data_i;
        RegMatZ:   cfg_q.mz     <= cfg_data_i;
        RegWidth:  cfg_q.width  <= cfg_data_i[10:0];
        RegHeight: cfg_q.height <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  e2p_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cfg_i           (cfg_q),
    .q_count_i       (q_count),
    .push_o          (push),
    .item_o          (push_item)
  );

  e2p_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head),
    .count_o (q_count)
  );

  e2p_back #(
    .PANO_MAX_WIDTH  (PANO_MAX_WIDTH),
    .PANO_MAX_HEIGHT (PANO_MAX_HEIGHT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_empty_i       (q_empty),
    .q_head_i        (head),
    .q_pop_o         (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

[src/e2p_checker.sv]
module e2p_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic        cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output beat dropped or changed under stall");

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

  a_reset_exit: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> s_axis_tready_o && !m_axis_tvalid_o)
    else $error("bad state on reset release");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config port not ready");

endmodule

bind equirect_to_perspective_sampler_unit e2p_checker u_e2p_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .cfg_ready_o     (cfg_ready_o)
);

[test/equirect_to_perspective_sampler_unit_test.sv]
module equirect_to_perspective_sampler_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  import e2p_pkg::*;

  typedef enum logic {CmdLoad = 1'b0, CmdSample = 1'b1} cmd_e;

  localparam logic [2:0] RegUnused = 3'd7;
  localparam int     PanoW     = 1024;
  localparam int     PanoH     = 512;
  localparam longint TurnFull  = 64'd16777216;
  localparam longint TurnHalf  = 64'd8388608;
  localparam longint TurnQuart = 64'd4194304;
  localparam longint RecipGain = 64'd10188014;
  localparam int     DrainWait = 60;
  localparam int     StallLimit = 3000;
  localparam int     NumPhases = 8;
  localparam int     PhaseBeats = 155;

  localparam longint AtanStep [20] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860, 10430,
    5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };

  typedef struct {
    cmd_e        cmd;
    int          col;
    int          row;
    logic [23:0] rgb;
    bit          typed;
    logic [23:0] want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_addr_i;
  logic [62:0] cfg_data_i;

  equirect_to_perspective_sampler_unit u_top (.*);

  logic [62:0] mat_x, mat_y, mat_z;
  logic [10:0] width_reg;
  logic [9:0]  height_reg;
  logic [23:0] pano_mem [int];
  logic [23:0] pending_rgb [$];

  int  mismatches;
  int  loads_sent;
  int  samples_sent;
  int  pixels_seen;
  int  idle_cycles;
  bit  send_quiet;
  bit  recv_quiet;
  int  stall_left;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic longint coef(logic [62:0] r, int k);
    logic [20:0] e;
    e = r[21*k +: 21];
    return longint'(signed'(e));
  endfunction

  function automatic longint ray_comp(logic [62:0] r, longint c, longint rw);
    return coef(r, 0) * c + coef(r, 1) * rw + coef(r, 2);
  endfunction

  function automatic longint vector_turns(input longint a, input longint b,
                                          output longint mag);
    longint ang, na, nb;
    ang = 0;
    if (a == 0 && b == 0) begin
      mag = 0;
      return 0;
    end
    if (a < 0) begin
      a = -a;
      b = -b;
      ang = TurnHalf;
    end
    for (int i = 0; i < 20; i++) begin
      if (b < 0) begin
        na = a - (b >>> i);
        nb = b + (a >>> i);
        ang -= AtanStep[i];
      end else begin
        na = a + (b >>> i);
        nb = b - (a >>> i);
        ang += AtanStep[i];
      end
      a = na;
      b = nb;
    end
    mag = a;
    return ang;
  endfunction

  task automatic locate_texels(input int col, input int row, output int u0, output int u1,
                               output int v0, output int v1, output int fu, output int fv);
    longint w, h, x, y, z, m, theta, phi, t, vq, u8, v8;
    w = width_reg;
    h = height_reg;
    if (w < 2) w = 2;
    if (w > PanoW) w = PanoW;
    if (h < 2) h = 2;
    if (h > PanoH) h = PanoH;
    if (col > PersMaxDim - 1) col = PersMaxDim - 1;
    if (row > PersMaxDim - 1) row = PersMaxDim - 1;
    x = ray_comp(mat_x, col, row);
    y = ray_comp(mat_y, col, row);
    z = ray_comp(mat_z, col, row);
    theta = vector_turns(z, x, m);
    m = (m * RecipGain) >> 24;
    phi = vector_turns(m, y, m);
    if (phi > TurnQuart) phi = TurnQuart;
    if (phi < -TurnQuart) phi = -TurnQuart;
    t = (theta + TurnHalf) & (TurnFull - 1);
    vq = phi + TurnQuart;
    u8 = ((t * w) >> 16) - 128;
    v8 = ((vq * h) >> 15) - 128;
    if (u8 < 0) u8 = 0;
    if (v8 < 0) v8 = 0;
    u0 = int'((u8 >> 8) % w);
    fu = int'(u8 & 255);
    u1 = (u0 + 1 == w) ? 0 : u0 + 1;
    v0 = int'(v8 >> 8);
    fv = int'(v8 & 255);
    if (v0 > h - 1) v0 = int'(h - 1);
    v1 = (v0 + 1 > h - 1) ? int'(h - 1) : v0 + 1;
  endtask

  function automatic logic [23:0] blend_rgb(int u0, int u1, int v0, int v1, int fu, int fv);
    logic [23:0] p [4];
    longint wt [4];
    longint acc;
    logic [23:0] res;
    p[0] = pano_mem[v0 * PanoW + u0];
    p[1] = pano_mem[v1 * PanoW + u0];
    p[2] = pano_mem[v0 * PanoW + u1];
    p[3] = pano_mem[v1 * PanoW + u1];
    wt[0] = (256 - fu) * (256 - fv);
    wt[1] = (256 - fu) * fv;
    wt[2] = fu * (256 - fv);
    wt[3] = fu * fv;
    for (int ch = 0; ch < 3; ch++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) acc += longint'(p[k][16 - 8*ch +: 8]) * wt[k];
      res[16 - 8*ch +: 8] = acc[23:16];
    end
    return res;
  endfunction

  function automatic int gap_len(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_beat(cmd_e cmd, int col, int row, logic [23:0] rgb,
                           bit typed, logic [23:0] want);
    int u0, u1, v0, v1, fu, fv;
    int gap;
    gap = gap_len(send_quiet);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = cmd;
    s_axis_tdata_i  = {rgb[7:0], rgb[15:8], rgb[23:16], row[11:0], col[11:0]};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (cmd == CmdLoad) begin
      loads_sent++;
      if (col < PanoW && row < PanoH) pano_mem[row * PanoW + col] = rgb;
    end else begin
      samples_sent++;
      if (typed) begin
        pending_rgb = {pending_rgb, want};
      end else begin
        locate_texels(col, row, u0, u1, v0, v1, fu, fv);
        pending_rgb = {pending_rgb, blend_rgb(u0, u1, v0, v1, fu, fv)};
      end
    end
    @(negedge clk_i);
  endtask

  task automatic fill_texel(int c, int r);
    if (!pano_mem.exists(r * PanoW + c)) send_beat(CmdLoad, c, r, 24'($urandom), 1'b0, '0);
  endtask

  task automatic send_sample(int col, int row);
    int u0, u1, v0, v1, fu, fv;
    locate_texels(col, row, u0, u1, v0, v1, fu, fv);
    fill_texel(u0, v0);
    fill_texel(u0, v1);
    fill_texel(u1, v0);
    fill_texel(u1, v1);
    send_beat(CmdSample, col, row, '0, 1'b0, '0);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [62:0] val);
    cfg_valid_i = 1'b1;
    cfg_addr_i  = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegMatX:   mat_x = val;
      RegMatY:   mat_y = val;
      RegMatZ:   mat_z = val;
      RegWidth:  width_reg = val[10:0];
      RegHeight: height_reg = val[9:0];
      default:   ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain_results();
    s_axis_tvalid_i = 1'b0;
    while (pending_rgb.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  function automatic logic [20:0] rand_coef();
    logic [20:0] e;
    int r;
    r = $urandom_range(0, 9);
    e = 21'($urandom);
    if (r == 0) return 21'h0FFFFF;
    if (r == 1) return 21'h100000;
    if (r == 2) return '0;
    return 21'(signed'(e) >>> $urandom_range(0, 18));
  endfunction

  function automatic logic [62:0] rand_row();
    return {rand_coef(), rand_coef(), rand_coef()};
  endfunction

  function automatic int rand_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 4095;
    return $urandom_range(0, 4095);
  endfunction

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_left      <= 0;
    end else if (recv_quiet) begin
      m_axis_tready_i <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left      <= stall_left - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
      stall_left      <= gap_len(1'b0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      pixels_seen++;
      if (pending_rgb.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat %h", m_axis_tdata_o);
      end else begin
        logic [23:0] want;
        want = pending_rgb.pop_front();
        if (m_axis_tdata_o[7:0] !== want[23:16] || m_axis_tdata_o[15:8] !== want[15:8] ||
            m_axis_tdata_o[23:16] !== want[7:0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel %0d: expected r=%h g=%h b=%h, got r=%h g=%h b=%h", pixels_seen,
                     want[23:16], want[15:8], want[7:0], m_axis_tdata_o[7:0],
                     m_axis_tdata_o[15:8], m_axis_tdata_o[23:16]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  stim_row_t directed [] = '{
    '{CmdLoad,   511, 255, 24'h123456, 1'b0, 24'h0},
    '{CmdLoad,   512, 255, 24'h123456, 1'b0, 24'h0},
    '{CmdLoad,   511, 256, 24'h123456, 1'b0, 24'h0},
    '{CmdLoad,   512, 256, 24'h123456, 1'b0, 24'h0},
    '{CmdSample, 0,   0,   24'h000000, 1'b1, 24'h123456},
    '{CmdSample, 4095, 4095, 24'hFFFFFF, 1'b1, 24'h123456},
    '{CmdLoad,   1024, 0,  24'hFFFFFF, 1'b0, 24'h0},
    '{CmdLoad,   0,   512, 24'hFFFFFF, 1'b0, 24'h0},
    '{CmdLoad,   4095, 4095, 24'h000000, 1'b0, 24'h0},
    '{CmdSample, 2048, 17, 24'hA5A5A5, 1'b1, 24'h123456},
    '{CmdLoad,   512, 255, 24'hFFFFFF, 1'b0, 24'h0},
    '{CmdLoad,   512, 256, 24'hFFFFFF, 1'b0, 24'h0},
    '{CmdSample, 100, 100, 24'h000000, 1'b0, 24'h0},
    '{CmdLoad,   1023, 511, 24'hFFFFFF, 1'b0, 24'h0},
    '{CmdLoad,   0,   0,   24'h000000, 1'b0, 24'h0}
  };

  logic [10:0] width_set  [NumPhases] = '{11'd1024, 11'd2, 11'd0, 11'd2047,
                                          11'd37, 11'd1, 11'd640, 11'd513};
  logic [9:0]  height_set [NumPhases] = '{10'd512, 10'd2, 10'd1023, 10'd0,
                                          10'd9, 10'd1, 10'd300, 10'd257};

  initial begin
    int phase_end;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i  = 1'b0;
    s_axis_tdata_i  = '0;
    cfg_valid_i     = 1'b0;
    cfg_addr_i      = RegMatX;
    cfg_data_i      = '0;
    mat_x = '0;
    mat_y = '0;
    mat_z = '0;
    width_reg  = 11'd1024;
    height_reg = 10'd512;
    mismatches = 0;
    loads_sent = 0;
    samples_sent = 0;
    pixels_seen = 0;
    idle_cycles = 0;
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i])
      send_beat(directed[i].cmd, directed[i].col, directed[i].row, directed[i].rgb,
                directed[i].typed, directed[i].want);
    drain_results();

    for (int p = 0; p < NumPhases; p++) begin
      send_quiet = (p == 3);
      recv_quiet = (p == 3) || (p == 6);
      write_reg(RegWidth, 63'(width_set[p]));
      write_reg(RegHeight, 63'(height_set[p]));
      if (p == 1) begin
        write_reg(RegMatX, {63{1'b1}});
        write_reg(RegMatY, {63{1'b1}});
        write_reg(RegMatZ, {63{1'b1}});
        write_reg(RegUnused, rand_row());
      end else begin
        write_reg(RegMatX, rand_row());
        write_reg(RegMatY, rand_row());
        write_reg(RegMatZ, rand_row());
      end
      phase_end = loads_sent + samples_sent + PhaseBeats;
      while (loads_sent + samples_sent < phase_end) begin
        if ($urandom_range(0, 5) == 0) send_beat(CmdLoad, rand_pos(), rand_pos() % 1024,
                                                 24'($urandom), 1'b0, '0);
        else send_sample(rand_pos(), rand_pos());
      end
      drain_results();
    end

    $display("covered %0d load beats and %0d sample beats over %0d register settings",
             loads_sent, samples_sent, NumPhases + 1);
    $display("output pixels compared: %0d, mismatches: %0d", pixels_seen, mismatches);
    if (mismatches == 0 && pending_rgb.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[equirect_to_perspective_sampler_unit.f]
src/e2p_pkg.sv
src/e2p_queue.sv
src/e2p_front.sv
src/e2p_cordic.sv
src/e2p_back.sv
src/equirect_to_perspective_sampler_unit.sv
src/e2p_checker.sv
test/equirect_to_perspective_sampler_unit_test.sv
